FILE: sv/paf_pkg.sv
// Shared types and codes of the proxy address filter.
`default_nettype none

package paf_pkg;

  localparam logic [1:0] CMD_SET_TYPE = 2'd0;
  localparam logic [1:0] CMD_ADD      = 2'd1;
  localparam logic [1:0] CMD_REMOVE   = 2'd2;
  localparam logic [1:0] CMD_CHECK    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_TYPE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic [7:0] TYPE_MAX = 8'd1;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  new_filter_type;
    logic        last_in_message;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       accepted;
    logic       current_type;
    logic [4:0] entry_count;
    logic       message_done;
  } out_item_t;

endpackage

`default_nettype wire

FILE: sv/paf_list_ram.sv
// Address list storage: one write port and one registered read port.
`default_nettype none

module paf_list_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [15:0]   wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [15:0]   rd_data
);

  logic [15:0] mem_r [DEPTH];
  logic [15:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: sv/proxy_address_filter.sv
// Proxy destination address filter: list memory plus a scanning sequencer.
//
// Each input item on in_valid/in_ready is one command: set filter type, add,
// remove or check an address. Every item yields exactly one result item on
// out_valid/out_ready with status, check answer, type and list count.
// The list sits in a RAM and is searched by one 16-bit comparator, one entry
// per cycle, with the registered RAM read issued the cycle before its compare.
// A set-type item goes straight to the done state without a list scan.
// Add, check and remove scan the listed entries until the address matches or
// the list ends. A remove that matches below the last slot then moves the
// later entries down by one slot. The block takes one item at a time;
// in_ready is high only when it is idle, which it becomes again as the result
// is loaded. The result register holds a finished result while out_ready is
// low, and a new item may be accepted meanwhile; its result waits until the
// register is free. Synchronous reset leaves an empty accept list and no result
// pending; the RAM needs no clearing since only listed slots are ever read.
`default_nettype none

module proxy_address_filter #(
  parameter int LIST_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire paf_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output paf_pkg::out_item_t      out_data
);

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_ACT   = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         cmd_r, cmd_nxt;
  logic [15:0]        addr_r, addr_nxt;
  logic               last_r, last_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               mode_r, mode_nxt;
  logic [CW-1:0]      ptr_r, ptr_nxt;
  logic               pipe_vld_r, pipe_vld_nxt;
  logic [CW-1:0]      pipe_idx_r, pipe_idx_nxt;
  logic               found_r, found_nxt;
  logic [CW-1:0]      pos_r, pos_nxt;
  logic [1:0]         status_r, status_nxt;
  logic               acc_r, acc_nxt;
  logic               out_valid_r, out_valid_nxt;
  paf_pkg::out_item_t out_data_r, out_data_nxt;

  logic               issue;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [15:0]        wr_data;
  logic               rd_en;
  logic [15:0]        rd_data;

  paf_list_ram #(
    .DEPTH (LIST_DEPTH),
    .AW    (IW)
  ) u_list_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (ptr_r[IW-1:0]),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign issue     = (ptr_r < count_r);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    addr_nxt      = addr_r;
    last_nxt      = last_r;
    count_nxt     = count_r;
    mode_nxt      = mode_r;
    ptr_nxt       = ptr_r;
    pipe_vld_nxt  = pipe_vld_r;
    pipe_idx_nxt  = pipe_idx_r;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    status_nxt    = status_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[IW-1:0];
    wr_data       = addr_r;
    rd_en         = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt      = in_data.command;
          addr_nxt     = in_data.address;
          last_nxt     = in_data.last_in_message;
          status_nxt   = paf_pkg::ST_OK;
          acc_nxt      = 1'b0;
          found_nxt    = 1'b0;
          ptr_nxt      = '0;
          pipe_vld_nxt = 1'b0;
          if (in_data.command == paf_pkg::CMD_SET_TYPE) begin
            if (in_data.new_filter_type > paf_pkg::TYPE_MAX) begin
              status_nxt = paf_pkg::ST_BAD_TYPE;
            end else begin
              mode_nxt  = in_data.new_filter_type[0];
              count_nxt = '0;
            end
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_en        = issue;
        pipe_vld_nxt = issue;
        pipe_idx_nxt = ptr_r;
        if (issue) begin
          ptr_nxt = CW'(ptr_r + 1'b1);
        end
        if (pipe_vld_r && (rd_data == addr_r)) begin
          found_nxt = 1'b1;
          pos_nxt   = pipe_idx_r;
          state_nxt = S_ACT;
        end else if (!issue && !pipe_vld_r) begin
          state_nxt = S_ACT;
        end
      end
      S_ACT: begin
        pipe_vld_nxt = 1'b0;
        state_nxt    = S_DONE;
        case (cmd_r)
          paf_pkg::CMD_ADD: begin
            if (!found_r) begin
              if (count_r == CW'(LIST_DEPTH)) begin
                status_nxt = paf_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = CW'(count_r + 1'b1);
              end
            end
          end
          paf_pkg::CMD_REMOVE: begin
            if (found_r) begin
              if (CW'(pos_r + 1'b1) < count_r) begin
                ptr_nxt   = CW'(pos_r + 1'b1);
                state_nxt = S_SHIFT;
              end else begin
                count_nxt = CW'(count_r - 1'b1);
              end
            end
          end
          paf_pkg::CMD_CHECK: begin
            acc_nxt = found_r ^ mode_r;
          end
          default: begin
            acc_nxt = 1'b0;
          end
        endcase
      end
      S_SHIFT: begin
        rd_en        = issue;
        pipe_vld_nxt = issue;
        pipe_idx_nxt = ptr_r;
        if (issue) begin
          ptr_nxt = CW'(ptr_r + 1'b1);
        end
        if (pipe_vld_r) begin
          wr_en   = 1'b1;
          wr_addr = IW'(pipe_idx_r - 1'b1);
          wr_data = rd_data;
        end
        if (!issue && !pipe_vld_r) begin
          count_nxt = CW'(count_r - 1'b1);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.status       = status_r;
          out_data_nxt.accepted     = acc_r;
          out_data_nxt.current_type = mode_r;
          out_data_nxt.entry_count  = 5'(count_r);
          out_data_nxt.message_done = last_r;
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pipe_vld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
      pipe_vld_r  <= pipe_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    addr_r     <= addr_nxt;
    last_r     <= last_nxt;
    ptr_r      <= ptr_nxt;
    pipe_idx_r <= pipe_idx_nxt;
    found_r    <= found_nxt;
    pos_r      <= pos_nxt;
    status_r   <= status_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(LIST_DEPTH))
    else $error("List count exceeds the list depth.");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("A result item appeared outside the done state.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("A second item was taken while one was in progress.");

  a_no_scan_on_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cmd_r != paf_pkg::CMD_SET_TYPE))
    else $error("A set-type item entered the list scan.");

endmodule

`default_nettype wire
